// ===== hdl/suts_pkg.sv =====
// Shared constants and codes for the sorted tag identifier table.
// No dependencies; used by the table RAM instance and the top level.
`timescale 1ns / 1ps

package suts_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ID_W        = 40;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Stream widths
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;
    localparam int COUNT_OUT_W = 7;

    // Request commands, carried on s_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

endpackage

// ===== hdl/suts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the sorted identifier table.
`timescale 1ns / 1ps

module suts_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/sorted_uid_table_search_top.sv =====
// Sorted table of 40-bit tag identifiers with insert and lookup requests.
// Depends on suts_pkg and suts_ram.
//
// Usage:
//   Input channel s_*: s_tuser selects the request (0 insert, 1 lookup),
//   s_tdata[39:0] carries the identifier, first UID byte in bits 39..32.
//   Output channel m_*: one response per request with found, accepted and
//   the entry count after the request.
// Timing:
//   One comparator and one registered-read table RAM serve a small sequencer.
//   Each binary search probe reads the table, then compares; a lookup needs
//   up to 7 probes on 64 entries. An insert then moves every entry above its
//   slot up by one place, each move a read and then a write, and ends with
//   the final write of the new identifier. An insert on a full table skips
//   the search and is answered without being stored. s_tready is high only
//   while the sequencer is idle, so the next request can be taken in the
//   cycle after a response is loaded.
// Reset:
//   rst_n clears the entry count and the sequencer; no clearing pass runs,
//   the table is read only below the entry count.
// Stall:
//   The response sits in an output register; a new request is taken while
//   it waits. A second response waits in the sequencer until m_tready.
`timescale 1ns / 1ps

module sorted_uid_table_search_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [suts_pkg::S_TDATA_W-1:0]  s_tdata,   // [39:0] tag_id
    input  logic                            s_tuser,   // [0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [suts_pkg::M_TDATA_W-1:0]  m_tdata    // [0] found, [1] accepted,
                                                       // [8:2] entry_count, rest 0
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                               state_reg, state_next;
    logic                                 cmd_reg, cmd_next;
    logic [suts_pkg::ID_W-1:0]            key_reg, key_next;
    logic [suts_pkg::CNT_W-1:0]           lo_reg, lo_next;
    logic [suts_pkg::CNT_W-1:0]           hi_reg, hi_next;
    logic [suts_pkg::CNT_W-1:0]           mid_reg, mid_next;
    logic [suts_pkg::CNT_W-1:0]           idx_reg, idx_next;
    logic [suts_pkg::CNT_W-1:0]           count_reg, count_next;
    logic                                 found_reg, found_next;
    logic                                 accepted_reg, accepted_next;
    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_found_reg, out_found_next;
    logic                                 out_accepted_reg, out_accepted_next;
    logic [suts_pkg::COUNT_OUT_W-1:0]     out_count_reg, out_count_next;

    logic                                 ram_we;
    logic [suts_pkg::ADDR_W-1:0]          ram_waddr;
    logic [suts_pkg::ID_W-1:0]            ram_wdata;
    logic [suts_pkg::ADDR_W-1:0]          ram_raddr;
    logic [suts_pkg::ID_W-1:0]            ram_rdata;

    logic [suts_pkg::CNT_W:0]             mid_sum;
    logic [suts_pkg::CNT_W-1:0]           mid_calc;
    logic [suts_pkg::CNT_W-1:0]           idx_dec;
    logic                                 key_eq;
    logic                                 key_lt;

    // table storage
    suts_ram #(
        .WIDTH (suts_pkg::ID_W),
        .DEPTH (suts_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared datapath: midpoint, index step and the one comparator
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[suts_pkg::CNT_W:1];
    assign idx_dec  = idx_reg - 1'b1;
    assign key_eq   = (ram_rdata == key_reg);
    assign key_lt   = (ram_rdata < key_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(suts_pkg::M_TDATA_W - suts_pkg::COUNT_OUT_W - 2){1'b0}},
                       out_count_reg, out_accepted_reg, out_found_reg};

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        key_next          = key_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        found_next        = found_reg;
        accepted_next     = accepted_reg;
        out_valid_next    = out_valid_reg;
        out_found_next    = out_found_reg;
        out_accepted_next = out_accepted_reg;
        out_count_next    = out_count_reg;
        ram_we            = 1'b0;
        ram_waddr         = idx_reg[suts_pkg::ADDR_W-1:0];
        ram_wdata         = ram_rdata;
        ram_raddr         = mid_calc[suts_pkg::ADDR_W-1:0];

        // response taken downstream
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next      = s_tuser;
                    key_next      = s_tdata[suts_pkg::ID_W-1:0];
                    lo_next       = '0;
                    hi_next       = count_reg;
                    found_next    = 1'b0;
                    accepted_next = 1'b0;
                    if (s_tuser == suts_pkg::CMD_INSERT &&
                        count_reg == suts_pkg::CNT_W'(suts_pkg::TABLE_DEPTH))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = ST_SRCH_CMP;
                end
                else if (cmd_reg == suts_pkg::CMD_LOOKUP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // insert slot is lo_reg; move entries above it
                    idx_next = count_reg;
                    if (count_reg > lo_reg)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_SRCH_CMP:
            begin
                state_next = ST_SRCH_RD;
                if (cmd_reg == suts_pkg::CMD_LOOKUP)
                begin
                    if (key_eq)
                    begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (key_lt)
                    begin
                        lo_next = mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                end
                else
                begin
                    // upper bound: equal entries stay below the new one
                    if (key_lt || key_eq)
                    begin
                        lo_next = mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                ram_raddr  = idx_dec[suts_pkg::ADDR_W-1:0];
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[suts_pkg::ADDR_W-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_dec;
                if (idx_dec > lo_reg)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we        = 1'b1;
                ram_waddr     = lo_reg[suts_pkg::ADDR_W-1:0];
                ram_wdata     = key_reg;
                count_next    = count_reg + 1'b1;
                accepted_next = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next    = 1'b1;
                    out_found_next    = found_reg;
                    out_accepted_next = accepted_reg;
                    out_count_next    = suts_pkg::COUNT_OUT_W'(count_reg);
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cmd_reg          <= suts_pkg::CMD_INSERT;
            key_reg          <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            mid_reg          <= '0;
            idx_reg          <= '0;
            count_reg        <= '0;
            found_reg        <= 1'b0;
            accepted_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_found_reg    <= 1'b0;
            out_accepted_reg <= 1'b0;
            out_count_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            key_reg          <= key_next;
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
            mid_reg          <= mid_next;
            idx_reg          <= idx_next;
            count_reg        <= count_next;
            found_reg        <= found_next;
            accepted_reg     <= accepted_next;
            out_valid_reg    <= out_valid_next;
            out_found_reg    <= out_found_next;
            out_accepted_reg <= out_accepted_next;
            out_count_reg    <= out_count_next;
        end
    end

    // entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= suts_pkg::CNT_W'(suts_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    // search window stays ordered and inside the filled part
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_RD) |-> (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("search window out of range");

    // the final write of an insert bumps the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not advance count");

    // entry moves only happen above the insert slot
    a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT_WR) |-> (idx_reg > lo_reg))
        else $error("entry move at or below insert slot");

    // a response never reports both a hit and a stored insert
    a_resp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_found_reg && out_accepted_reg))
        else $error("response flags both found and accepted");

endmodule
